@@ sv/assert_macros.svh @@
// Assertion macros shared by the windowed peak compressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication between two conditions.
`define ASSERT_IMPLIES(lbl, pre, post, msg) `ASSERT_CLKD(lbl, (pre) |-> (post), msg)

`endif

@@ sv/wpc_pkg.sv @@
// Package with types, constants and helpers of the windowed peak compressor.
package wpc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int GAIN_FRAC_BITS   = 15;
  localparam int GAIN_W           = 16;
  localparam int THRESH_W         = 24;
  localparam int WLEN_W           = 16;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 24;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << GAIN_FRAC_BITS);

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 24'd8388608;
  localparam logic [GAIN_W-1:0]   REDUCTION_RST = 16'd262;
  localparam logic [GAIN_W-1:0]   ATTACK_RST    = 16'd3277;
  localparam logic [GAIN_W-1:0]   RELEASE_RST   = 16'd327;
  localparam logic [GAIN_W-1:0]   OUT_GAIN_RST  = 16'd32768;
  localparam logic [WLEN_W-1:0]   WLEN_RST      = 16'd48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD      = 3'd0,
    CFG_REDUCTION_GAIN = 3'd1,
    CFG_ATTACK_COEF    = 3'd2,
    CFG_RELEASE_COEF   = 3'd3,
    CFG_OUTPUT_GAIN    = 3'd4,
    CFG_WINDOW_LENGTH  = 3'd5
  } cfg_index_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GMUL,
    BK_GAPP,
    BK_LCG,
    BK_RCG,
    BK_LOG,
    BK_ROG,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [WLEN_W-1:0]   window_length;
  } win_cfg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] reduction_gain;
    logic [GAIN_W-1:0] attack_coef;
    logic [GAIN_W-1:0] release_coef;
    logic [GAIN_W-1:0] output_gain;
  } gain_cfg_t;

  typedef struct packed {
    logic upd;
    logic over;
  } job_ctrl_t;

  function automatic logic [GAIN_W-1:0] sat_unity(input logic [GAIN_W-1:0] g);
    return (g > UNITY) ? UNITY : g;
  endfunction

endpackage

@@ sv/wpc_fifo.sv @@
// Small register queue between the classifying front end and the arithmetic back end.
module wpc_fifo #(
  parameter int DW    = 50,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/wpc_front.sv @@
// Front end: takes sample pairs, tracks the window peak and decides on gain updates.
module wpc_front #(
  parameter int SW = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [SW-1:0] left_i,
  input  logic signed [SW-1:0] right_i,
  input  wpc_pkg::win_cfg_t   cfg_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic signed [SW-1:0] job_left_o,
  output logic signed [SW-1:0] job_right_o,
  output wpc_pkg::job_ctrl_t  job_ctrl_o
);
  import wpc_pkg::*;

  localparam int CW = (SW > THRESH_W) ? SW : THRESH_W;

  logic                 in_valid_q;
  logic signed [SW-1:0] left_q, right_q;
  logic [SW-1:0]        peak_q;
  logic [WLEN_W-1:0]    count_q;

  logic signed [SW:0]   sum;
  logic [SW-1:0]        mix;
  logic [SW-1:0]        mag;
  logic [SW-1:0]        peak_new;
  logic                 win;
  logic                 push;

  // The mix is floor((l + r) / 2); its magnitude always fits SW bits unsigned.
  assign sum      = (SW+1)'(left_q) + (SW+1)'(right_q);
  assign mix      = sum[SW:1];
  assign mag      = mix[SW-1] ? (~mix + 1'b1) : mix;
  assign peak_new = (mag > peak_q) ? mag : peak_q;
  assign win      = (count_q >= cfg_i.window_length);

  assign push        = in_valid_q && job_ready_i;
  assign in_ready_o  = !in_valid_q || push;
  assign job_valid_o = in_valid_q;
  assign job_left_o  = left_q;
  assign job_right_o = right_q;
  assign job_ctrl_o  = '{upd: win, over: (CW'(cfg_i.threshold) < CW'(peak_new))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      peak_q     <= '0;
      count_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (push) begin
        if (win) begin
          peak_q  <= '0;
          count_q <= WLEN_W'(1);
        end else begin
          peak_q  <= peak_new;
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

endmodule

@@ sv/wpc_back.sv @@
// Back end: gain smoothing and channel scaling on one shared multiplier.
module wpc_back #(
  parameter int SW = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_pop_o,
  input  logic signed [SW-1:0]   job_left_i,
  input  logic signed [SW-1:0]   job_right_i,
  input  wpc_pkg::job_ctrl_t     job_ctrl_i,
  input  wpc_pkg::gain_cfg_t     cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [SW-1:0]   left_out_o,
  output logic signed [SW-1:0]   right_out_o,
  output logic [wpc_pkg::GAIN_W-1:0] gain_o
);
  import wpc_pkg::*;

  localparam int AW = (SW > GAIN_W + 1) ? SW : GAIN_W + 1;
  localparam int BW = GAIN_W + 1;
  localparam int PW = AW + BW;

  back_state_e state_q, state_d;

  logic signed [SW-1:0] l_q, r_q, l1_q, r1_q, lo_q;
  logic                 over_q, rising_q;
  logic [GAIN_W-1:0]    cg_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  logic                 out_valid_q;
  logic signed [SW-1:0] left_out_q, right_out_q;
  logic [GAIN_W-1:0]    gain_out_q;

  logic [GAIN_W-1:0]    target, gdiff, gcoef, og_sat, step;
  logic                 rising;
  logic                 out_load;
  logic signed [SW-1:0] prod_smp;

  assign target   = over_q ? sat_unity(cfg_i.reduction_gain) : UNITY;
  assign rising   = (target > cg_q);
  assign gdiff    = rising ? (target - cg_q) : (cg_q - target);
  assign gcoef    = rising ? sat_unity(cfg_i.attack_coef) : sat_unity(cfg_i.release_coef);
  assign og_sat   = sat_unity(cfg_i.output_gain);
  assign step     = prod_q[GAIN_FRAC_BITS+GAIN_W-1:GAIN_FRAC_BITS];
  assign prod_smp = prod_q[GAIN_FRAC_BITS+SW-1:GAIN_FRAC_BITS];
  assign prod_d   = mul_a * mul_b;
  assign out_load = (state_q == BK_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = job_ctrl_i.upd ? BK_GMUL : BK_LCG;
        end
      end
      BK_GMUL: begin
        mul_a   = AW'($signed({1'b0, gdiff}));
        mul_b   = $signed({1'b0, gcoef});
        state_d = BK_GAPP;
      end
      BK_GAPP: begin
        state_d = BK_LCG;
      end
      BK_LCG: begin
        mul_a   = AW'(l_q);
        mul_b   = $signed({1'b0, cg_q});
        state_d = BK_RCG;
      end
      BK_RCG: begin
        mul_a   = AW'(r_q);
        mul_b   = $signed({1'b0, cg_q});
        state_d = BK_LOG;
      end
      BK_LOG: begin
        mul_a   = AW'(l1_q);
        mul_b   = $signed({1'b0, og_sat});
        state_d = BK_ROG;
      end
      BK_ROG: begin
        mul_a   = AW'(r1_q);
        mul_b   = $signed({1'b0, og_sat});
        state_d = BK_FIN;
      end
      BK_FIN: begin
        // The right product is kept on the multiplier while the output register is busy.
        mul_a = AW'(r1_q);
        mul_b = $signed({1'b0, og_sat});
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cg_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_GAPP) begin
        cg_q <= rising_q ? (cg_q + step) : (cg_q - step);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (job_pop_o) begin
      l_q    <= job_left_i;
      r_q    <= job_right_i;
      over_q <= job_ctrl_i.over;
    end
    if (state_q == BK_GMUL) begin
      rising_q <= rising;
    end
    if (state_q == BK_RCG) begin
      l1_q <= prod_smp;
    end
    if (state_q == BK_LOG) begin
      r1_q <= prod_smp;
    end
    if (state_q == BK_ROG) begin
      lo_q <= prod_smp;
    end
    if (out_load) begin
      left_out_q  <= lo_q;
      right_out_q <= prod_smp;
      gain_out_q  <= cg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign gain_o      = gain_out_q;

endmodule

@@ sv/windowed_peak_compressor_top.sv @@
// Top level of the windowed peak compressor: configuration registers, front, queue, back.
//
//  Channel   Direction  Handshake                   Content
//  s_axis    in         s_axis_tvalid/tready        left_in, right_in
//  m_axis    out        m_axis_tvalid/tready        left_out, right_out, gain_level
//  cfg       in         cfg_valid_i/cfg_ready_o     register index and value
//
// The single shared multiplier performs every product in turn; per item the back end runs
// LCG, RCG, LOG, ROG, FIN, after GMUL, GAPP when a window closes and the gain is updated.
// The front end adds one register stage and a queue lets it run ahead of the back end.
// Reset loads the register defaults and clears peak, window count and gain.
// A full output register stalls the back end, and a full queue stalls the input.
`include "assert_macros.svh"

module windowed_peak_compressor_top #(
  parameter int SAMPLE_WIDTH = wpc_pkg::SAMPLE_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = wpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // left_in, right_in, zero padding
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // left_out, right_out, gain_level, zero padding
  output logic [((2*SAMPLE_WIDTH+wpc_pkg::GAIN_W+7)/8)*8-1:0] m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wpc_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [wpc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import wpc_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int OUT_W = ((2*SW+GAIN_W+7)/8)*8;
  localparam int JOB_W = 2*SW + $bits(job_ctrl_t);

  logic [THRESH_W-1:0] threshold_q;
  logic [GAIN_W-1:0]   reduction_q, attack_q, release_q, out_gain_q;
  logic [WLEN_W-1:0]   wlen_q;

  win_cfg_t   win_cfg;
  gain_cfg_t  gain_cfg;

  logic                 job_valid, job_push, job_pop;
  logic                 fifo_full, fifo_empty;
  logic signed [SW-1:0] job_left, job_right;
  job_ctrl_t            job_ctrl;
  logic [JOB_W-1:0]     fifo_wr, fifo_rd;

  logic signed [SW-1:0] out_left, out_right;
  logic [GAIN_W-1:0]    out_gain;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      reduction_q <= REDUCTION_RST;
      attack_q    <= ATTACK_RST;
      release_q   <= RELEASE_RST;
      out_gain_q  <= OUT_GAIN_RST;
      wlen_q      <= WLEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_THRESHOLD:      threshold_q <= cfg_data_i[THRESH_W-1:0];
        CFG_REDUCTION_GAIN: reduction_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ATTACK_COEF:    attack_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_RELEASE_COEF:   release_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_OUTPUT_GAIN:    out_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_WINDOW_LENGTH:  wlen_q      <= cfg_data_i[WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign win_cfg  = '{threshold: threshold_q, window_length: wlen_q};
  assign gain_cfg = '{reduction_gain: reduction_q, attack_coef: attack_q,
                      release_coef: release_q, output_gain: out_gain_q};

  wpc_front #(
    .SW (SW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .left_i      (s_axis_tdata[SW-1:0]),
    .right_i     (s_axis_tdata[2*SW-1:SW]),
    .cfg_i       (win_cfg),
    .job_valid_o (job_valid),
    .job_ready_i (!fifo_full),
    .job_left_o  (job_left),
    .job_right_o (job_right),
    .job_ctrl_o  (job_ctrl)
  );

  assign job_push = job_valid && !fifo_full;
  assign fifo_wr  = {job_ctrl, job_right, job_left};

  wpc_fifo #(
    .DW    (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (fifo_wr),
    .full_o  (fifo_full),
    .pop_i   (job_pop),
    .data_o  (fifo_rd),
    .empty_o (fifo_empty)
  );

  wpc_back #(
    .SW (SW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_pop_o   (job_pop),
    .job_left_i  (fifo_rd[SW-1:0]),
    .job_right_i (fifo_rd[2*SW-1:SW]),
    .job_ctrl_i  (job_ctrl_t'(fifo_rd[JOB_W-1:2*SW])),
    .cfg_i       (gain_cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_out_o  (out_left),
    .right_out_o (out_right),
    .gain_o      (out_gain)
  );

  assign m_axis_tdata = OUT_W'({out_gain, out_right, out_left});

  `ASSERT_IMPLIES(a_gain_le_unity, m_axis_tvalid, out_gain <= UNITY, "gain above unity")
  `ASSERT_IMPLIES(a_no_push_full, job_push, !fifo_full, "queue written while full")
  `ASSERT_IMPLIES(a_no_pop_empty, job_pop, !fifo_empty, "queue read while empty")

endmodule
